// ----- hw/rtl/lca_pkg.sv -----
// lca_pkg: shared types, constants and sequencer states of the binary-lifting LCA block.
// No dependencies. Used by the channel interfaces, lca_binary_lifting_table and the bench.
package lca_pkg;

  localparam int NODE_W       = 10;
  localparam int DEPTH_W      = 10;
  localparam int MAX_NODES    = 1 << NODE_W;
  localparam int LCA_LEVELS   = 10;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  localparam depth_t DEPTH_MAX = '1;

  // func field codes
  localparam logic FUNC_ADD   = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_ADD_DEP,
    ST_ADD_DEPW,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_Q_DEPX,
    ST_Q_DEPY,
    ST_Q_DIFF,
    ST_Q_LRD,
    ST_Q_LWR,
    ST_Q_CMP,
    ST_Q_URD,
    ST_Q_UWR,
    ST_Q_PAR,
    ST_Q_PARW,
    ST_Q_RDEP,
    ST_DONE
  } lca_state_t;

endpackage

// ----- hw/rtl/lca_in_if.sv -----
// lca_in_if: input channel (valid/ready) carrying add and query items.
// Depends on lca_pkg.
interface lca_in_if import lca_pkg::*; ();
  logic  valid;
  logic  ready;
  logic  func;
  node_t node_a;
  node_t node_b;

  modport source (output valid, func, node_a, node_b, input ready);
  modport sink   (input valid, func, node_a, node_b, output ready);
endinterface

// ----- hw/rtl/lca_out_if.sv -----
// lca_out_if: result channel (valid/ready) carrying ancestor node and its depth.
// Depends on lca_pkg.
interface lca_out_if import lca_pkg::*; ();
  logic   valid;
  logic   ready;
  node_t  ancestor_node;
  depth_t node_depth;

  modport source (output valid, ancestor_node, node_depth, input ready);
  modport sink   (input valid, ancestor_node, node_depth, output ready);
endinterface

// ----- hw/rtl/lca_binary_lifting_table.sv -----
// lca_binary_lifting_table: binary-lifting ancestor and depth tables with a sequencer.
// Depends on lca_pkg, lca_in_if, lca_out_if.
//
// Usage:
//   in_chan  : func = add (node_a under parent node_b) or query (LCA of node_a, node_b).
//   out_chan : one result per item: ancestor_node and node_depth. For an add the
//              added node is echoed with its new depth.
//   One item is worked on at a time; in_chan.ready is high only while the
//   sequencer is idle. A jump-table step issues a read and then takes the
//   data, as the table RAM read is registered.
//   Add:   reads the parent depth, writes depth and level 0, then levels above.
//   Query: reads both depths, lifts the deeper node by the difference, lifts
//          both from the top level down, then reads the answer's depth.
//   Node 0 is the sentinel; its row and depth read as zero whatever the RAM holds,
//   so reset needs no clearing pass and the block is ready straight after reset.
//   Results wait in an output register; while out_chan stalls the finished item
//   holds there and the next item may already be taken and worked on, but its
//   result is loaded only once the register has been freed.
module lca_binary_lifting_table import lca_pkg::*; #(
  parameter int LEVELS = LCA_LEVELS
) (
  input  logic      clk,
  input  logic      rst_n,
  lca_in_if.sink    in_chan,
  lca_out_if.source out_chan
);

  localparam int JT_DEPTH = MAX_NODES * LEVELS;
  localparam int JA_W     = $clog2(JT_DEPTH);
  localparam int LVL_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam logic [JA_W-1:0]  LEVELS_A = JA_W'(LEVELS);
  localparam logic [LVL_W-1:0] LVL_TOP  = LVL_W'(LEVELS - 1);

  typedef logic [JA_W-1:0]  jaddr_t;
  typedef logic [LVL_W-1:0] lvl_t;

  function automatic jaddr_t jaddr(input node_t n, input lvl_t l);
    return JA_W'(n) * LEVELS_A + JA_W'(l);
  endfunction

  // memories
  node_t  jt_mem [JT_DEPTH];
  depth_t dt_mem [MAX_NODES];

  logic   jt_we, jt_re;
  jaddr_t jt_waddr, jt_raddr_a, jt_raddr_b;
  node_t  jt_wdata;
  node_t  jt_rdata_a_r, jt_rdata_b_r;

  logic   dt_we, dt_re;
  node_t  dt_waddr, dt_raddr;
  depth_t dt_wdata;
  depth_t dt_rdata_r;

  always_ff @(posedge clk) begin
    if (jt_we) jt_mem[jt_waddr] <= jt_wdata;
    if (jt_re) begin
      jt_rdata_a_r <= jt_mem[jt_raddr_a];
      jt_rdata_b_r <= jt_mem[jt_raddr_b];
    end
  end

  always_ff @(posedge clk) begin
    if (dt_we) dt_mem[dt_waddr] <= dt_wdata;
    if (dt_re) dt_rdata_r <= dt_mem[dt_raddr];
  end

  // sequencer and datapath registers
  lca_state_t state_r, state_nxt;
  node_t  x_r, x_nxt;
  node_t  y_r, y_nxt;
  node_t  cur_r, cur_nxt;
  lvl_t   lvl_r, lvl_nxt;
  depth_t diff_r, diff_nxt;
  depth_t dx_r, dx_nxt;
  depth_t res_depth_r, res_depth_nxt;
  logic   out_valid_r, out_valid_nxt;
  node_t  out_node_r, out_node_nxt;
  depth_t out_depth_r, out_depth_nxt;

  logic   in_xfer;
  logic   out_free;
  node_t  jx_val, jy_val, jcur_val;
  depth_t dq_x, dq_y;
  depth_t add_depth;

  assign in_xfer  = in_chan.valid && in_chan.ready;
  assign out_free = !out_valid_r || out_chan.ready;

  // sentinel node 0 reads as zero
  assign jx_val    = (x_r == '0)   ? '0 : jt_rdata_a_r;
  assign jy_val    = (y_r == '0)   ? '0 : jt_rdata_b_r;
  assign jcur_val  = (cur_r == '0) ? '0 : jt_rdata_a_r;
  assign dq_x      = (x_r == '0)   ? '0 : dt_rdata_r;
  assign dq_y      = (y_r == '0)   ? '0 : dt_rdata_r;
  assign add_depth = (dq_y == DEPTH_MAX) ? DEPTH_MAX : dq_y + 1'b1;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_chan.func == FUNC_QUERY)  state_nxt = ST_Q_DEPX;
          else if (in_chan.node_a == '0)   state_nxt = ST_DONE;
          else                             state_nxt = ST_ADD_DEP;
        end
      end
      ST_ADD_DEP:  state_nxt = ST_ADD_DEPW;
      ST_ADD_DEPW: state_nxt = (LEVELS == 1) ? ST_DONE : ST_ADD_RD;
      ST_ADD_RD:   state_nxt = ST_ADD_WR;
      ST_ADD_WR:   state_nxt = (lvl_r == LVL_TOP) ? ST_DONE : ST_ADD_RD;
      ST_Q_DEPX:   state_nxt = ST_Q_DEPY;
      ST_Q_DEPY:   state_nxt = ST_Q_DIFF;
      ST_Q_DIFF:   state_nxt = ST_Q_LRD;
      ST_Q_LRD: begin
        if (diff_r[0])              state_nxt = ST_Q_LWR;
        else if (lvl_r == LVL_TOP)  state_nxt = ST_Q_CMP;
      end
      ST_Q_LWR:    state_nxt = (lvl_r == LVL_TOP) ? ST_Q_CMP : ST_Q_LRD;
      ST_Q_CMP:    state_nxt = (x_r == y_r) ? ST_Q_RDEP : ST_Q_URD;
      ST_Q_URD:    state_nxt = ST_Q_UWR;
      ST_Q_UWR:    state_nxt = (lvl_r == '0) ? ST_Q_PAR : ST_Q_URD;
      ST_Q_PAR:    state_nxt = ST_Q_PARW;
      ST_Q_PARW:   state_nxt = ST_Q_RDEP;
      ST_Q_RDEP:   state_nxt = ST_DONE;
      ST_DONE: begin
        // ST_Q_RDEP's data is taken on entry to ST_DONE via res_depth_nxt
        if (out_free) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // memory controls and handshake outputs
  always_comb begin
    jt_we      = 1'b0;
    jt_re      = 1'b0;
    jt_waddr   = jaddr(x_r, lvl_r);
    jt_wdata   = jcur_val;
    jt_raddr_a = jaddr(x_r, lvl_r);
    jt_raddr_b = jaddr(y_r, lvl_r);
    dt_we      = 1'b0;
    dt_re      = 1'b0;
    dt_waddr   = x_r;
    dt_wdata   = add_depth;
    dt_raddr   = x_r;
    unique case (state_r)
      ST_ADD_DEP: begin
        dt_re    = 1'b1;
        dt_raddr = y_r;
      end
      ST_ADD_DEPW: begin
        dt_we    = 1'b1;
        jt_we    = 1'b1;
        jt_waddr = jaddr(x_r, '0);
        jt_wdata = y_r;
      end
      ST_ADD_RD: begin
        jt_re      = 1'b1;
        jt_raddr_a = jaddr(cur_r, lvl_r - 1'b1);
      end
      ST_ADD_WR: begin
        jt_we = 1'b1;
      end
      ST_Q_DEPX: begin
        dt_re = 1'b1;
      end
      ST_Q_DEPY: begin
        dt_re    = 1'b1;
        dt_raddr = y_r;
      end
      ST_Q_LRD: begin
        jt_re = diff_r[0];
      end
      ST_Q_URD: begin
        jt_re = 1'b1;
      end
      ST_Q_PAR: begin
        jt_re      = 1'b1;
        jt_raddr_a = jaddr(x_r, '0);
      end
      ST_Q_PARW: begin
        // depth of the parent, addressed straight from the table output
        dt_re    = 1'b1;
        dt_raddr = jx_val;
      end
      ST_Q_CMP: begin
        // equal nodes: depth of the answer is read here
        dt_re = (x_r == y_r);
      end
      ST_Q_RDEP: begin
        dt_re = 1'b0;
      end
      default: begin
      end
    endcase
  end

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.ancestor_node = out_node_r;
  assign out_chan.node_depth    = out_depth_r;

  // datapath next values
  always_comb begin
    x_nxt         = x_r;
    y_nxt         = y_r;
    cur_nxt       = cur_r;
    lvl_nxt       = lvl_r;
    diff_nxt      = diff_r;
    dx_nxt        = dx_r;
    res_depth_nxt = res_depth_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    out_node_nxt  = out_node_r;
    out_depth_nxt = out_depth_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          x_nxt         = in_chan.node_a;
          y_nxt         = in_chan.node_b;
          res_depth_nxt = '0;
        end
      end
      ST_ADD_DEPW: begin
        res_depth_nxt = add_depth;
        cur_nxt       = y_r;
        lvl_nxt       = lvl_t'(1 % LEVELS);
      end
      ST_ADD_WR: begin
        cur_nxt = jcur_val;
        lvl_nxt = lvl_r + 1'b1;
      end
      ST_Q_DEPY: begin
        dx_nxt = dq_x;
      end
      ST_Q_DIFF: begin
        lvl_nxt = '0;
        if (dx_r < dq_y) begin
          x_nxt    = y_r;
          y_nxt    = x_r;
          diff_nxt = dq_y - dx_r;
        end else begin
          diff_nxt = dx_r - dq_y;
        end
      end
      ST_Q_LRD: begin
        if (!diff_r[0]) begin
          diff_nxt = diff_r >> 1;
          lvl_nxt  = lvl_r + 1'b1;
        end
      end
      ST_Q_LWR: begin
        x_nxt    = jx_val;
        diff_nxt = diff_r >> 1;
        lvl_nxt  = lvl_r + 1'b1;
      end
      ST_Q_CMP: begin
        lvl_nxt = LVL_TOP;
      end
      ST_Q_UWR: begin
        if (jx_val != jy_val) begin
          x_nxt = jx_val;
          y_nxt = jy_val;
        end
        lvl_nxt = lvl_r - 1'b1;
      end
      ST_Q_PARW: begin
        x_nxt = jx_val;
      end
      ST_Q_RDEP: begin
        res_depth_nxt = dq_x;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = x_r;
          out_depth_nxt = res_depth_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    cur_r       <= cur_nxt;
    lvl_r       <= lvl_nxt;
    diff_r      <= diff_nxt;
    dx_r        <= dx_nxt;
    res_depth_r <= res_depth_nxt;
    out_node_r  <= out_node_nxt;
    out_depth_r <= out_depth_nxt;
  end

endmodule

// ----- bench/lca_tb_pkg.sv -----
`timescale 1ns / 1ps
// lca_tb_pkg: tree predictor and store of expected answers for the LCA bench.
// Depends on lca_pkg.
package lca_tb_pkg;
  import lca_pkg::*;

  typedef struct packed {
    node_t  anc;
    depth_t dep;
  } lca_answer_t;

  class lca_scoreboard;
    node_t       anc_row [MAX_NODES][LCA_LEVELS];
    depth_t      depth_of [MAX_NODES];
    lca_answer_t expected_lca [$];
    int unsigned n_adds;
    int unsigned n_queries;
    int unsigned n_checked;
    int unsigned n_fail;
    depth_t      deepest;

    function new();
      foreach (anc_row[n, l]) anc_row[n][l] = '0;
      foreach (depth_of[n]) depth_of[n] = '0;
      n_adds    = 0;
      n_queries = 0;
      n_checked = 0;
      n_fail    = 0;
      deepest   = '0;
    endfunction

    // For one accepted transfer, updates the tree copy if it adds a node and queues its answer.
    function void note_request(logic f, node_t a, node_t b);
      lca_answer_t ans;
      node_t       x;
      node_t       y;
      node_t       t;
      depth_t      diff;
      int          lvl;
      if (f == FUNC_ADD) begin
        n_adds++;
        if (a == '0) begin
          ans.anc = '0;
          ans.dep = '0;
        end else begin
          ans.dep = (depth_of[b] == DEPTH_MAX) ? DEPTH_MAX : depth_of[b] + 1'b1;
          depth_of[a] = ans.dep;
          anc_row[a][0] = b;
          // each level reads the row as it stands now, own row included
          for (lvl = 1; lvl < LCA_LEVELS; lvl++)
            anc_row[a][lvl] = anc_row[anc_row[a][lvl-1]][lvl-1];
          ans.anc = a;
          if (ans.dep > deepest) deepest = ans.dep;
        end
      end else begin
        n_queries++;
        x = a;
        y = b;
        if (depth_of[x] < depth_of[y]) begin
          t = x;
          x = y;
          y = t;
        end
        diff = depth_of[x] - depth_of[y];
        for (lvl = 0; lvl < LCA_LEVELS; lvl++)
          if (diff[lvl]) x = anc_row[x][lvl];
        if (x == y) begin
          ans.anc = x;
        end else begin
          for (lvl = LCA_LEVELS - 1; lvl >= 0; lvl--) begin
            if (anc_row[x][lvl] != anc_row[y][lvl]) begin
              x = anc_row[x][lvl];
              y = anc_row[y][lvl];
            end
          end
          ans.anc = anc_row[x][0];
        end
        ans.dep = depth_of[ans.anc];
      end
      expected_lca = {expected_lca, ans};
    endfunction

    function void check_answer(node_t anc, depth_t dep);
      lca_answer_t exp_ans;
      n_checked++;
      if (expected_lca.size() == 0) begin
        $error("unexpected result: ancestor_node %0d node_depth %0d", anc, dep);
        n_fail++;
        return;
      end
      exp_ans = expected_lca.pop_front();
      if (anc !== exp_ans.anc) begin
        $error("ancestor_node: expected %0d, got %0d", exp_ans.anc, anc);
        n_fail++;
      end
      if (dep !== exp_ans.dep) begin
        $error("node_depth: expected %0d, got %0d", exp_ans.dep, dep);
        n_fail++;
      end
    endfunction

    function int unsigned pending();
      return expected_lca.size();
    endfunction
  endclass

endpackage

// ----- bench/tb_lca_binary_lifting_table.sv -----
`timescale 1ns / 1ps
// tb_lca_binary_lifting_table: builds trees of add items, asks LCA queries and checks
// every answer against a predicted copy of the tables. Depends on lca_pkg, lca_tb_pkg,
// lca_in_if, lca_out_if and lca_binary_lifting_table.
module tb_lca_binary_lifting_table;
  import lca_pkg::*;
  import lca_tb_pkg::*;

  localparam int unsigned QUIET_LIMIT  = 5000;
  localparam int unsigned RANDOM_ITEMS = 440;
  localparam int unsigned CHAIN_NODES  = 150;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic clk = 1'b0;
  logic rst_n;

  lca_in_if  in_chan ();
  lca_out_if out_chan ();

  lca_binary_lifting_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  always #5 clk = ~clk;

  lca_scoreboard sb;

  // nodes that hold a defined row; only these are ever read back
  node_t       tree_nodes [$];
  bit          in_tree [MAX_NODES];
  int unsigned burst_left = 0;

  int unsigned rx_cyc = 0;
  int unsigned hold_left = 0;
  int unsigned holds_done = 0;
  int unsigned quiet_cycles = 0;

  // Called at a clock edge; returns at the edge of the transfer.
  task automatic send_item(input logic f, input node_t a, input node_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 60);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid  <= 1'b1;
    in_chan.func   <= f;
    in_chan.node_a <= a;
    in_chan.node_b <= b;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    sb.note_request(f, a, b);
  endtask

  task automatic add_node(input node_t a, input node_t b);
    send_item(FUNC_ADD, a, b);
    if (a != '0 && !in_tree[a]) begin
      in_tree[a] = 1'b1;
      tree_nodes = {tree_nodes, a};
    end
  endtask

  function automatic node_t pick_known();
    return tree_nodes[$urandom_range(0, tree_nodes.size() - 1)];
  endfunction

  // Receiver: result check, stall pattern and two long hold-offs.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready)
        sb.check_answer(out_chan.ancestor_node, out_chan.node_depth);
      rx_cyc++;
      if (hold_left == 0 && holds_done < 2 &&
          sb.n_checked >= ((holds_done == 0) ? 40 : 400)) begin
        hold_left = HOLD_CYCLES;
        holds_done++;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        case ((rx_cyc / 256) % 4)
          0:       out_chan.ready <= 1'b1;
          1:       out_chan.ready <= 1'($urandom_range(0, 1));
          2:       out_chan.ready <= ($urandom_range(0, 3) == 0);
          default: out_chan.ready <= ((rx_cyc % 7) > 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("no transfer for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    int unsigned sel;
    int unsigned pr;
    node_t       fresh;
    node_t       parent;
    node_t       qa;
    node_t       qb;
    sb = new();
    in_chan.valid  = 1'b0;
    in_chan.func   = FUNC_ADD;
    in_chan.node_a = '0;
    in_chan.node_b = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: two roots, alternating bit patterns, swaps, sentinel, overwrite, loops
    add_node('1, '0);
    add_node(node_t'(1), '1);
    add_node(node_t'(512), node_t'(1));
    add_node(node_t'(2), '0);
    add_node(node_t'(341), node_t'(512));
    add_node(node_t'(682), node_t'(512));
    send_item(FUNC_QUERY, node_t'(341), node_t'(682));
    send_item(FUNC_QUERY, node_t'(682), node_t'(341));
    send_item(FUNC_QUERY, node_t'(341), '1);
    send_item(FUNC_QUERY, '1, node_t'(341));
    send_item(FUNC_QUERY, node_t'(2), node_t'(512));
    send_item(FUNC_QUERY, node_t'(1), '0);
    send_item(FUNC_QUERY, node_t'(512), node_t'(512));
    add_node('0, '1);
    add_node(node_t'(682), node_t'(2));
    send_item(FUNC_QUERY, node_t'(682), node_t'(341));
    add_node('1, '1);
    send_item(FUNC_QUERY, '1, node_t'(1));
    add_node(node_t'(1), node_t'(341));
    send_item(FUNC_QUERY, node_t'(341), node_t'(2));
    add_node('1, '0);

    // random: mostly tree growth and queries, some overwrites and sentinel adds
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        if (tree_nodes.size() >= MAX_NODES - 1) begin
          add_node(pick_known(), pick_known());
        end else begin
          do fresh = node_t'($urandom_range(1, MAX_NODES - 1)); while (in_tree[fresh]);
          pr = $urandom_range(0, 19);
          // lean on the newest node so that chains get deep
          parent = (pr == 0) ? '0 : (pr < 10) ? tree_nodes[$] : pick_known();
          add_node(fresh, parent);
        end
      end else if (sel < 45) begin
        add_node(pick_known(), pick_known());
      end else if (sel < 48) begin
        add_node('0, ($urandom_range(0, 1) == 1) ? pick_known() : '0);
      end else begin
        qa = pick_known();
        pr = $urandom_range(0, 9);
        qb = (pr == 0) ? '0 : (pr == 1) ? qa : pick_known();
        send_item(FUNC_QUERY, qa, qb);
      end
    end

    // one long chain hung from node 0, then a loop at its top and a self loop
    for (k = 1; k < CHAIN_NODES; k++)
      add_node(node_t'(k), node_t'(k - 1));
    add_node(node_t'(1), node_t'(CHAIN_NODES - 1));
    add_node('1, '1);
    send_item(FUNC_QUERY, '1, node_t'(2));
    for (k = 0; k < 40; k++)
      send_item(FUNC_QUERY, pick_known(),
                ($urandom_range(0, 4) == 0) ? '0 : pick_known());

    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("covered %0d adds and %0d queries, %0d results checked, deepest depth %0d",
             sb.n_adds, sb.n_queries, sb.n_checked, sb.deepest);
    if (sb.n_fail == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
